// ===== design/tpq_pkg.sv =====
// tpq_pkg: shared constants for the triangle point query block
// no dependencies; used by tpq_geom and triangle_point_query
`default_nettype none
package tpq_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS = 8;
	localparam int AREA_BITS_MAX = 64;

	function automatic int area_bits(input int cb);
		return (2 * cb + 3 > AREA_BITS_MAX) ? AREA_BITS_MAX : 2 * cb + 3;
	endfunction
endpackage
`default_nettype wire

// ===== design/tpq_geom.sv =====
// tpq_geom: front pipeline, edge signs, plane normal, interpolation numerator
// depends on tpq_pkg; six stages, feeds the divider chain
`default_nettype none
module tpq_geom #(
	parameter int COORD_BITS = tpq_pkg::COORD_BITS_DEF,
	localparam int DW = COORD_BITS + 1,
	localparam int PW = 2 * DW,
	localparam int NW = PW + 1,
	localparam int NMW = NW + DW + 1,
	localparam int RW = NMW + 1,
	localparam int QW = COORD_BITS + 1,
	localparam int AW = tpq_pkg::area_bits(COORD_BITS),
	localparam int SW = 4 + COORD_BITS + AW
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          vld_in,
	input  wire signed [COORD_BITS-1:0]  a_x,
	input  wire signed [COORD_BITS-1:0]  a_y,
	input  wire signed [COORD_BITS-1:0]  a_z,
	input  wire signed [COORD_BITS-1:0]  b_x,
	input  wire signed [COORD_BITS-1:0]  b_y,
	input  wire signed [COORD_BITS-1:0]  b_z,
	input  wire signed [COORD_BITS-1:0]  c_x,
	input  wire signed [COORD_BITS-1:0]  c_y,
	input  wire signed [COORD_BITS-1:0]  c_z,
	input  wire signed [COORD_BITS-1:0]  query_x,
	input  wire signed [COORD_BITS-1:0]  query_y,
	output logic                         vld_s6,
	output logic [RW-1:0]                rem_s6,
	output logic [NW:0]                  den_s6,
	output logic [SW-1:0]                side_s6
);
	localparam int MW = 2 * DW + 1;

	logic signed [COORD_BITS-1:0] vtx_x [3];
	logic signed [COORD_BITS-1:0] vtx_y [3];

	logic [5:1] vld_q;

	// stage 1: coordinate differences
	logic signed [DW-1:0] ea_s1 [3], eb_s1 [3], ec_s1 [3], ed_s1 [3];
	logic signed [DW-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1, dpx_s1, dpy_s1;
	logic signed [COORD_BITS-1:0] az_s1;
	// stage 2: products
	logic signed [PW-1:0] t1_s2 [3], t2_s2 [3];
	logic signed [PW-1:0] uyvz_s2, uzvy_s2, uzvx_s2, uxvz_s2, uxvy_s2, uyvx_s2;
	logic signed [DW-1:0] dpx_s2, dpy_s2;
	logic signed [COORD_BITS-1:0] az_s2;
	// stage 3: normal and inside test
	logic signed [NW-1:0] nx_s3, ny_s3, nz_s3;
	logic signed [DW-1:0] dpx_s3, dpy_s3;
	logic signed [COORD_BITS-1:0] az_s3;
	logic inside_s3;
	// stage 4: partial products of the numerator
	logic signed [MW-1:0] pxl_s4, pxh_s4, pyl_s4, pyh_s4;
	logic [NW-1:0] ad_s4;
	logic [AW-1:0] area_s4;
	logic zvalid_s4, nzpos_s4, inside_s4;
	logic signed [COORD_BITS-1:0] az_s4;
	// stage 5: numerator
	logic signed [NMW-1:0] num_s5;
	logic [NW-1:0] ad_s5;
	logic [AW-1:0] area_s5;
	logic zvalid_s5, nzpos_s5, inside_s5;
	logic signed [COORD_BITS-1:0] az_s5;

	logic signed [NW-1:0] edge_val [3];
	logic [2:0] edge_neg;
	logic [NW-1:0] anz;
	logic [NMW-1:0] an;
	logic [RW-1:0] n_ext;
	logic neg_q;

	assign vtx_x[0] = a_x;
	assign vtx_x[1] = b_x;
	assign vtx_x[2] = c_x;
	assign vtx_y[0] = a_y;
	assign vtx_y[1] = b_y;
	assign vtx_y[2] = c_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_q  <= {vld_q[4:1], vld_in};
			vld_s6 <= vld_q[5];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ea_s1[k] <= DW'(query_x) - DW'(vtx_x[(k+1)%3]);
				eb_s1[k] <= DW'(vtx_y[k]) - DW'(vtx_y[(k+1)%3]);
				ec_s1[k] <= DW'(vtx_x[k]) - DW'(vtx_x[(k+1)%3]);
				ed_s1[k] <= DW'(query_y) - DW'(vtx_y[(k+1)%3]);
			end
			ux_s1  <= DW'(c_x) - DW'(b_x);
			uy_s1  <= DW'(c_y) - DW'(b_y);
			uz_s1  <= DW'(c_z) - DW'(b_z);
			vx_s1  <= DW'(a_x) - DW'(b_x);
			vy_s1  <= DW'(a_y) - DW'(b_y);
			vz_s1  <= DW'(a_z) - DW'(b_z);
			dpx_s1 <= DW'(query_x) - DW'(a_x);
			dpy_s1 <= DW'(query_y) - DW'(a_y);
			az_s1  <= a_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				t1_s2[k] <= PW'(ea_s1[k]) * PW'(eb_s1[k]);
				t2_s2[k] <= PW'(ec_s1[k]) * PW'(ed_s1[k]);
			end
			uyvz_s2 <= PW'(uy_s1) * PW'(vz_s1);
			uzvy_s2 <= PW'(uz_s1) * PW'(vy_s1);
			uzvx_s2 <= PW'(uz_s1) * PW'(vx_s1);
			uxvz_s2 <= PW'(ux_s1) * PW'(vz_s1);
			uxvy_s2 <= PW'(ux_s1) * PW'(vy_s1);
			uyvx_s2 <= PW'(uy_s1) * PW'(vx_s1);
			dpx_s2  <= dpx_s1;
			dpy_s2  <= dpy_s1;
			az_s2   <= az_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			edge_val[k] = NW'(t1_s2[k]) - NW'(t2_s2[k]);
			edge_neg[k] = edge_val[k][NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3     <= NW'(uyvz_s2) - NW'(uzvy_s2);
			ny_s3     <= NW'(uzvx_s2) - NW'(uxvz_s2);
			nz_s3     <= NW'(uxvy_s2) - NW'(uyvx_s2);
			inside_s3 <= (edge_neg[0] == edge_neg[1]) && (edge_neg[1] == edge_neg[2]);
			dpx_s3    <= dpx_s2;
			dpy_s3    <= dpy_s2;
			az_s3     <= az_s2;
		end
	end

	assign anz = nz_s3[NW-1] ? NW'(-nz_s3) : NW'(nz_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			pxl_s4    <= MW'($signed({1'b0, nx_s3[DW-1:0]})) * MW'(dpx_s3);
			pxh_s4    <= MW'($signed(nx_s3[NW-1:DW])) * MW'(dpx_s3);
			pyl_s4    <= MW'($signed({1'b0, ny_s3[DW-1:0]})) * MW'(dpy_s3);
			pyh_s4    <= MW'($signed(ny_s3[NW-1:DW])) * MW'(dpy_s3);
			ad_s4     <= anz;
			area_s4   <= (|(anz >> AW)) ? '1 : anz[AW-1:0];
			zvalid_s4 <= |nz_s3;
			nzpos_s4  <= !nz_s3[NW-1] && (|nz_s3);
			inside_s4 <= inside_s3;
			az_s4     <= az_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5    <= (NMW'(pxh_s4) <<< DW) + NMW'(pxl_s4)
				+ (NMW'(pyh_s4) <<< DW) + NMW'(pyl_s4);
			ad_s5     <= ad_s4;
			area_s5   <= area_s4;
			zvalid_s5 <= zvalid_s4;
			nzpos_s5  <= nzpos_s4;
			inside_s5 <= inside_s4;
			az_s5     <= az_s4;
		end
	end

	// rounded quotient of an / ad is floor((2an + ad) / 2ad)
	assign an    = num_s5[NMW-1] ? NMW'(-num_s5) : NMW'(num_s5);
	assign n_ext = {an, 1'b0} + RW'(ad_s5);
	assign neg_q = num_s5[NMW-1] != nzpos_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s6  <= n_ext;
			den_s6  <= {ad_s5, 1'b0};
			side_s6 <= {inside_s5, zvalid_s5, neg_q,
				n_ext >= (RW'({ad_s5, 1'b0}) << QW), az_s5, area_s5};
		end
	end
endmodule
`default_nettype wire

// ===== design/tpq_div_cell.sv =====
// tpq_div_cell: one restoring-division cell, resolves one quotient bit
// depends on tpq_pkg widths via parameters from the top level
`default_nettype none
module tpq_div_cell #(
	parameter int RW = 78,
	parameter int DNW = 52,
	parameter int QW = 25,
	parameter int SW = 79,
	parameter int SHIFT = 0
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             en,
	input  wire             vld_in,
	input  wire [RW-1:0]    rem_in,
	input  wire [DNW-1:0]   den_in,
	input  wire [QW-1:0]    quo_in,
	input  wire [SW-1:0]    side_in,
	output logic            vld_q,
	output logic [RW-1:0]   rem_q,
	output logic [DNW-1:0]  den_q,
	output logic [QW-1:0]   quo_q,
	output logic [SW-1:0]   side_q
);
	logic [RW-1:0] sub;
	logic take;
	logic [QW-1:0] quo_n;

	always_comb begin
		sub = RW'(den_in) << SHIFT;
		take = rem_in >= sub;
		quo_n = quo_in;
		quo_n[SHIFT] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? rem_in - sub : rem_in;
			den_q  <= den_in;
			quo_q  <= quo_n;
			side_q <= side_in;
		end
	end
endmodule
`default_nettype wire

// ===== design/triangle_point_query.sv =====
// triangle_point_query: top level, geometry front end, divider cell chain, output skid
// depends on tpq_pkg, tpq_geom, tpq_div_cell
//
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_ready   | a_x a_y a_z b_x b_y b_z c_x c_y c_z query_x query_y
// out      | out_valid / out_ready | inside_res z_valid z_value area_doubled
//
// one transaction per cycle sustained while the skid register is empty
// six front stages, COORD_BITS + 1 divider cells (one quotient bit each), one output stage
// in_ready drops only when both output register and skid register hold results
// arst_n clears all valid bits; no clearing pass
`default_nettype none
module triangle_point_query #(
	parameter int COORD_BITS = tpq_pkg::COORD_BITS_DEF,
	localparam int AW = tpq_pkg::area_bits(COORD_BITS)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire signed [COORD_BITS-1:0]  a_x,
	input  wire signed [COORD_BITS-1:0]  a_y,
	input  wire signed [COORD_BITS-1:0]  a_z,
	input  wire signed [COORD_BITS-1:0]  b_x,
	input  wire signed [COORD_BITS-1:0]  b_y,
	input  wire signed [COORD_BITS-1:0]  b_z,
	input  wire signed [COORD_BITS-1:0]  c_x,
	input  wire signed [COORD_BITS-1:0]  c_y,
	input  wire signed [COORD_BITS-1:0]  c_z,
	input  wire signed [COORD_BITS-1:0]  query_x,
	input  wire signed [COORD_BITS-1:0]  query_y,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         inside_res,
	output logic                         z_valid,
	output logic signed [COORD_BITS-1:0] z_value,
	output logic [AW-1:0]                area_doubled
);
	localparam int DW = COORD_BITS + 1;
	localparam int NW = 2 * DW + 1;
	localparam int NMW = NW + DW + 1;
	localparam int RW = NMW + 1;
	localparam int DNW = NW + 1;
	localparam int QW = COORD_BITS + 1;
	localparam int SW = 4 + COORD_BITS + AW;
	localparam int ZW = QW + 3;
	localparam int OW = 2 + COORD_BITS + AW;

	logic pipe_en;
	logic vld_c [QW+1];
	logic [RW-1:0] rem_c [QW+1];
	logic [DNW-1:0] den_c [QW+1];
	logic [QW-1:0] quo_c [QW+1];
	logic [SW-1:0] side_c [QW+1];

	logic inside_f, zvalid_f, neg_f, ovf_f;
	logic signed [COORD_BITS-1:0] az_f;
	logic [AW-1:0] area_f;
	logic [QW:0] qmag;
	logic signed [ZW-1:0] qsgn, zsum;
	logic signed [COORD_BITS-1:0] zsat;
	logic [OW-1:0] res_f;

	logic out_vld_q, skid_vld_q;
	logic [OW-1:0] out_q, skid_q;
	logic push;

	assign pipe_en  = !skid_vld_q;
	assign in_ready = pipe_en;

	tpq_geom #(.COORD_BITS(COORD_BITS)) u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.vld_in  (in_valid),
		.a_x     (a_x),
		.a_y     (a_y),
		.a_z     (a_z),
		.b_x     (b_x),
		.b_y     (b_y),
		.b_z     (b_z),
		.c_x     (c_x),
		.c_y     (c_y),
		.c_z     (c_z),
		.query_x (query_x),
		.query_y (query_y),
		.vld_s6  (vld_c[0]),
		.rem_s6  (rem_c[0]),
		.den_s6  (den_c[0]),
		.side_s6 (side_c[0])
	);

	assign quo_c[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		tpq_div_cell #(
			.RW(RW), .DNW(DNW), .QW(QW), .SW(SW), .SHIFT(QW - 1 - i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (pipe_en),
			.vld_in  (vld_c[i]),
			.rem_in  (rem_c[i]),
			.den_in  (den_c[i]),
			.quo_in  (quo_c[i]),
			.side_in (side_c[i]),
			.vld_q   (vld_c[i+1]),
			.rem_q   (rem_c[i+1]),
			.den_q   (den_c[i+1]),
			.quo_q   (quo_c[i+1]),
			.side_q  (side_c[i+1])
		);
	end

	// remainder and divisor of the last cell only keep the chain uniform
	always_comb begin
		{inside_f, zvalid_f, neg_f, ovf_f, az_f, area_f} = side_c[QW];
		qmag = ovf_f ? (QW+1)'(1) << QW : {1'b0, quo_c[QW]};
		qsgn = neg_f ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
		zsum = ZW'(az_f) + qsgn;
		if (zsum[ZW-1:COORD_BITS-1] == '0 || zsum[ZW-1:COORD_BITS-1] == '1) begin
			zsat = zsum[COORD_BITS-1:0];
		end else if (zsum[ZW-1]) begin
			zsat = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			zsat = {1'b0, {(COORD_BITS-1){1'b1}}};
		end
		res_f = {inside_f, zvalid_f, zvalid_f ? zsat : COORD_BITS'(0), area_f};
	end

	assign push = vld_c[QW] && pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !out_ready) begin
			if (push) begin
				skid_vld_q <= 1'b1;
			end
		end else if (skid_vld_q) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !out_ready) begin
			if (push) begin
				skid_q <= res_f;
			end
		end else if (skid_vld_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res_f;
		end
	end

	assign out_valid = out_vld_q;
	assign {inside_res, z_valid, z_value, area_doubled} = out_q;

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !z_valid |-> z_value == '0)
		else $error("z_value nonzero with flat normal");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a transaction while output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready))
		else $error("skid filled without an output stall");

	a_area_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && z_valid |-> area_doubled != '0)
		else $error("valid z with zero area");
endmodule
`default_nettype wire
